// ===== hdl/pfse_pkg.sv =====
// Shared types, constants and helper functions for the Playfair stream encryptor
`default_nettype none

package pfse_pkg;

    // square geometry and alphabet
    localparam int SQ_SIDE  = 5;
    localparam int SQ_CELLS = 25;
    localparam int ALPHA    = 26;

    // letter indexes, 0 is 'a'
    localparam logic [4:0] LET_I    = 5'd8;
    localparam logic [4:0] LET_J    = 5'd9;
    localparam logic [4:0] LET_Q    = 5'd16;
    localparam logic [4:0] LET_X    = 5'd23;
    localparam logic [4:0] LET_Z    = 5'd25;
    localparam logic [4:0] LET_LAST = 5'd25;

    // ascii anchors
    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [6:0] ASCII_A       = 7'd97;

    typedef logic [4:0] letter_idx_t;
    typedef logic [4:0] cell_idx_t;
    typedef logic [2:0] coord_t;

    // input item kinds
    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_MSG   = 2'd2,
        CMD_END   = 2'd3
    } in_cmd_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_RD_A,
        ST_RD_B,
        ST_CALC,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_D,
        ST_LOAD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic sweep;
        logic rd_b;
        logic calc;
        logic sq_b;
        logic sq_d;
        logic load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic close_start;
        logic pair_start;
        logic sweep_last;
        logic obuf_empty;
    } ctrl_stat_t;

    typedef struct packed {
        logic        valid;
        letter_idx_t idx;
    } fold_t;

    typedef struct packed {
        cell_idx_t oa;
        cell_idx_t ob;
    } cell_pair_t;

    // byte to letter index, i folded into j
    function automatic fold_t fold_byte(input logic [7:0] c);
        fold_t      r;
        logic [7:0] k;
        r = '0;
        k = '0;
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
        begin
            k = c - ASCII_UPPER_A;
            r.valid = 1'b1;
        end
        else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
        begin
            k = c - ASCII_LOWER_A;
            r.valid = 1'b1;
        end
        r.idx = k[4:0];
        if (r.idx == LET_I)
        begin
            r.idx = LET_J;
        end
        return r;
    endfunction

    // row of a cell, c / 5 as multiply by 13 and shift for c below 25
    function automatic coord_t cell_row(input cell_idx_t c);
        logic [8:0] p;
        p = 9'({4'd0, c}) * 9'd13;
        return p[8:6];
    endfunction

    function automatic coord_t cell_col(input cell_idx_t c);
        logic [4:0] rr;
        rr = 5'({2'd0, cell_row(c)}) * 5'(SQ_SIDE);
        return 3'(c - rr);
    endfunction

    function automatic cell_idx_t make_cell(input coord_t r, input coord_t col);
        return 5'({2'd0, r}) * 5'(SQ_SIDE) + 5'({2'd0, col});
    endfunction

    function automatic coord_t wrap_inc(input coord_t v);
        return (v == 3'(SQ_SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    // output cells for a pair of input cells
    function automatic cell_pair_t pair_cells(input cell_idx_t ca, input cell_idx_t cb);
        cell_pair_t r;
        coord_t     ra;
        coord_t     rb;
        coord_t     ka;
        coord_t     kb;
        ra = cell_row(ca);
        rb = cell_row(cb);
        ka = cell_col(ca);
        kb = cell_col(cb);
        if (ka == kb)
        begin
            r.oa = make_cell(wrap_inc(ra), ka);
            r.ob = make_cell(wrap_inc(rb), kb);
        end
        else if (ra == rb)
        begin
            r.oa = make_cell(ra, wrap_inc(ka));
            r.ob = make_cell(rb, wrap_inc(kb));
        end
        else
        begin
            r.oa = make_cell(ra, kb);
            r.ob = make_cell(rb, ka);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pfse_ram.sv =====
// Generic single write port RAM with registered read
`default_nettype none

module pfse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/pfse_controller.sv =====
// Sequencer for key close sweep and pair encryption
`default_nettype none

module pfse_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pfse_pkg::ctrl_stat_t  stat,
    output pfse_pkg::ctrl_cmd_t        cmd
);

    pfse_pkg::state_t state_reg;
    pfse_pkg::state_t state_next;
    logic             accept;

    assign accept = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfse_pkg::ST_IDLE:
            begin
                if (accept && stat.close_start)
                begin
                    state_next = pfse_pkg::ST_CLOSE;
                end
                else if (accept && stat.pair_start)
                begin
                    state_next = pfse_pkg::ST_RD_A;
                end
            end
            pfse_pkg::ST_CLOSE:
            begin
                if (stat.sweep_last)
                begin
                    state_next = pfse_pkg::ST_IDLE;
                end
            end
            pfse_pkg::ST_RD_A: state_next = pfse_pkg::ST_RD_B;
            pfse_pkg::ST_RD_B: state_next = pfse_pkg::ST_CALC;
            pfse_pkg::ST_CALC: state_next = pfse_pkg::ST_SQ_A;
            pfse_pkg::ST_SQ_A: state_next = pfse_pkg::ST_SQ_B;
            pfse_pkg::ST_SQ_B: state_next = pfse_pkg::ST_SQ_D;
            pfse_pkg::ST_SQ_D: state_next = pfse_pkg::ST_LOAD;
            pfse_pkg::ST_LOAD:
            begin
                if (stat.obuf_empty)
                begin
                    state_next = pfse_pkg::ST_IDLE;
                end
            end
            default: state_next = pfse_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.accept = accept;
        case (state_reg)
            pfse_pkg::ST_IDLE:  in_ready  = 1'b1;
            pfse_pkg::ST_CLOSE: cmd.sweep = 1'b1;
            pfse_pkg::ST_RD_B:  cmd.rd_b  = 1'b1;
            pfse_pkg::ST_CALC:  cmd.calc  = 1'b1;
            pfse_pkg::ST_SQ_B:  cmd.sq_b  = 1'b1;
            pfse_pkg::ST_SQ_D:  cmd.sq_d  = 1'b1;
            pfse_pkg::ST_LOAD:  cmd.load  = stat.obuf_empty;
            default:            in_ready  = 1'b0;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfse_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pfse_datapath.sv =====
// Letter square storage, pair state, cell arithmetic and output buffer
`default_nettype none

module pfse_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pfse_pkg::ctrl_cmd_t  cmd,
    output pfse_pkg::ctrl_stat_t      stat,
    input  wire logic [1:0]           in_kind,
    input  wire logic [7:0]           in_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [6:0]                out_letter,
    output logic                      out_last
);

    // control state
    logic [pfse_pkg::ALPHA-1:0] seen_reg, seen_next;
    logic [4:0]                 fill_reg, fill_next;
    logic                       closed_reg, closed_next;
    logic                       pend_valid_reg, pend_valid_next;
    pfse_pkg::letter_idx_t      pend_reg, pend_next;
    pfse_pkg::letter_idx_t      sweep_reg, sweep_next;
    logic [1:0]                 cnt_reg, cnt_next;

    // payload
    pfse_pkg::letter_idx_t      a_reg, a_next;
    pfse_pkg::letter_idx_t      b_reg, b_next;
    pfse_pkg::cell_idx_t        ca_reg;
    pfse_pkg::cell_idx_t        oa_reg;
    pfse_pkg::cell_idx_t        ob_reg;
    pfse_pkg::letter_idx_t      lt0_reg;
    pfse_pkg::letter_idx_t      lt1_reg;
    pfse_pkg::letter_idx_t      ob0_reg;
    pfse_pkg::letter_idx_t      ob1_reg;

    pfse_pkg::fold_t            fold;
    pfse_pkg::in_cmd_t          kind;
    logic                       key_place;
    logic                       place_req;
    logic                       place_en;
    pfse_pkg::letter_idx_t      place_k;
    pfse_pkg::cell_idx_t        cell_raddr;
    pfse_pkg::cell_idx_t        cell_rdata;
    pfse_pkg::cell_idx_t        sq_raddr;
    pfse_pkg::letter_idx_t      sq_rdata;
    pfse_pkg::cell_pair_t       cells;
    logic                       pop;

    assign fold = pfse_pkg::fold_byte(in_byte);
    assign kind = pfse_pkg::in_cmd_t'(in_kind);

    // letter placement, from a key item or the close sweep
    assign key_place = cmd.accept && (kind == pfse_pkg::CMD_KEY) && !closed_reg && fold.valid;
    assign place_k   = cmd.sweep ? sweep_reg : fold.idx;
    assign place_req = key_place || (cmd.sweep && (sweep_reg != pfse_pkg::LET_I));
    assign place_en  = place_req && !seen_reg[place_k]
                       && (fill_reg < 5'(pfse_pkg::SQ_CELLS));

    // square and cell stores
    assign cell_raddr = cmd.rd_b ? b_reg : a_reg;
    assign sq_raddr   = cmd.sq_b ? ob_reg : oa_reg;

    pfse_ram #(
        .WIDTH (5),
        .DEPTH (pfse_pkg::SQ_CELLS)
    ) u_square (
        .clk     (clk),
        .wr_en   (place_en),
        .wr_addr (fill_reg),
        .wr_data (place_k),
        .rd_addr (sq_raddr),
        .rd_data (sq_rdata)
    );

    pfse_ram #(
        .WIDTH (5),
        .DEPTH (pfse_pkg::ALPHA)
    ) u_cell (
        .clk     (clk),
        .wr_en   (place_en),
        .wr_addr (place_k),
        .wr_data (fill_reg),
        .rd_addr (cell_raddr),
        .rd_data (cell_rdata)
    );

    // output cells from the captured first cell and the second read
    assign cells = pfse_pkg::pair_cells(ca_reg, cell_rdata);

    // item decode, key state update and status
    always_comb
    begin
        seen_next        = seen_reg;
        fill_next        = fill_reg;
        closed_next      = closed_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        sweep_next       = sweep_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        stat.close_start = 1'b0;
        stat.pair_start  = 1'b0;
        stat.sweep_last  = (sweep_reg == pfse_pkg::LET_LAST);
        stat.obuf_empty  = (cnt_reg == 2'd0);

        if (place_en)
        begin
            seen_next[place_k] = 1'b1;
            fill_next          = fill_reg + 5'd1;
        end

        if (cmd.sweep)
        begin
            sweep_next = sweep_reg + 5'd1;
            if (sweep_reg == pfse_pkg::LET_LAST)
            begin
                closed_next = 1'b1;
            end
        end

        if (cmd.accept)
        begin
            case (kind)
                pfse_pkg::CMD_CLOSE:
                begin
                    if (!closed_reg)
                    begin
                        stat.close_start = 1'b1;
                        sweep_next       = '0;
                    end
                end
                pfse_pkg::CMD_MSG:
                begin
                    if (closed_reg && fold.valid)
                    begin
                        if (!pend_valid_reg)
                        begin
                            pend_valid_next = 1'b1;
                            pend_next       = fold.idx;
                        end
                        else if (fold.idx == pend_reg)
                        begin
                            // doubled letter: filler partner, letter stays waiting
                            stat.pair_start = 1'b1;
                            a_next          = pend_reg;
                            b_next          = (pend_reg == pfse_pkg::LET_X) ?
                                              pfse_pkg::LET_Q : pfse_pkg::LET_X;
                        end
                        else
                        begin
                            stat.pair_start = 1'b1;
                            a_next          = pend_reg;
                            b_next          = fold.idx;
                            pend_valid_next = 1'b0;
                        end
                    end
                end
                pfse_pkg::CMD_END:
                begin
                    if (closed_reg && pend_valid_reg)
                    begin
                        // odd tail padded
                        stat.pair_start = 1'b1;
                        a_next          = pend_reg;
                        b_next          = (pend_reg == pfse_pkg::LET_Z) ?
                                          pfse_pkg::LET_X : pfse_pkg::LET_Z;
                        pend_valid_next = 1'b0;
                    end
                end
                default:
                begin
                    stat.pair_start = 1'b0;
                end
            endcase
        end
    end

    // two letter output buffer
    assign out_valid  = (cnt_reg != 2'd0);
    assign pop        = out_valid && out_ready;
    assign out_last   = (cnt_reg == 2'd1);
    assign out_letter = pfse_pkg::ASCII_A + 7'((cnt_reg == 2'd2) ? ob0_reg : ob1_reg);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = 2'd2;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            fill_reg       <= '0;
            closed_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            sweep_reg      <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            seen_reg       <= seen_next;
            fill_reg       <= fill_next;
            closed_reg     <= closed_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            sweep_reg      <= sweep_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (cmd.rd_b)
        begin
            ca_reg <= cell_rdata;
        end
        if (cmd.calc)
        begin
            oa_reg <= cells.oa;
            ob_reg <= cells.ob;
        end
        if (cmd.sq_b)
        begin
            lt0_reg <= sq_rdata;
        end
        if (cmd.sq_d)
        begin
            lt1_reg <= sq_rdata;
        end
        if (cmd.load)
        begin
            ob0_reg <= lt0_reg;
            ob1_reg <= lt1_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/playfair_stream_encryptor.sv =====
// Top level of the Playfair stream encryptor
//
// Input stream s_axis: tuser carries the command (key byte, close key,
// message byte, end of message), tdata the ASCII byte. Key bytes build the
// 5x5 square, close key fills the rest, message bytes are encrypted in pairs.
// Output stream m_axis: one ciphertext letter per item, tlast on the second
// letter of each pair.
// Key bytes, message bytes that only wait for a partner, and ignored items
// leave the controller idle. Close key runs a sweep over the 26 letters, one
// letter a cycle. An item that completes a pair runs two reads of the
// letter-to-cell store, the cell arithmetic, two reads of the square, then a
// load into the two letter output buffer, from which the first letter goes
// out on m_axis.
// The next item is accepted while the buffered pair still waits; a further
// pair holds in its load step until the buffer has drained, so a stalled
// receiver stops input once one pair is buffered and another is ready.
// Reset clears the key state: a new square must be keyed and closed.
`default_nettype none

module playfair_stream_encryptor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  wire logic [1:0] s_axis_tuser,   // [1:0] cmd
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [6:0] cipher_letter, [7] zero
    output logic            m_axis_tlast    // pair_end
);

    pfse_pkg::ctrl_cmd_t  cmd;
    pfse_pkg::ctrl_stat_t stat;
    logic [6:0]           letter;

    pfse_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfse_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_axis_tuser),
        .in_byte    (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_letter (letter),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, letter};

    // a pair is only loaded into an empty buffer
    assert property (@(posedge clk) disable iff (!rst_n) cmd.load |-> stat.obuf_empty)
        else $error("pair loaded over a buffered pair");

    // no input is taken during the sweep, the cell arithmetic or the second square read
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep || cmd.calc || cmd.sq_b) |-> !s_axis_tready)
        else $error("input ready during sequence");

    // a taken first letter is always followed by its second letter
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("first letter not followed by pair end");

endmodule

`default_nettype wire

// ===== verif/tb_playfair_stream_encryptor.sv =====
// Self-checking testbench for the Playfair stream encryptor
`timescale 1ns / 100ps

module tb_playfair_stream_encryptor;

    localparam int N_DIRECTED     = 27;
    localparam int ITEMS_PER_RUN  = 110;
    localparam int N_RUNS         = 4;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 3000;

    // one row of the directed table; silent rows are known to give no letters
    typedef struct packed {
        pfse_pkg::in_cmd_t cmd;
        logic [7:0]        text;
        logic              silent;
    } stim_row_t;

    typedef struct packed {
        logic [6:0] letter;
        logic       pair_end;
    } cipher_out_t;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{pfse_pkg::CMD_KEY,   "P",   1'b1},
        '{pfse_pkg::CMD_KEY,   "l",   1'b1},
        '{pfse_pkg::CMD_KEY,   "a",   1'b1},
        '{pfse_pkg::CMD_KEY,   "y",   1'b1},
        '{pfse_pkg::CMD_KEY,   "F",   1'b1},
        '{pfse_pkg::CMD_KEY,   "i",   1'b1},  // folds into j
        '{pfse_pkg::CMD_KEY,   "a",   1'b1},  // repeated key letter
        '{pfse_pkg::CMD_KEY,   8'h00, 1'b1},
        '{pfse_pkg::CMD_KEY,   8'hFF, 1'b1},
        '{pfse_pkg::CMD_KEY,   "Z",   1'b1},
        '{pfse_pkg::CMD_MSG,   "q",   1'b1},  // message before the key is closed
        '{pfse_pkg::CMD_END,   8'h00, 1'b1},  // end before the key is closed
        '{pfse_pkg::CMD_CLOSE, 8'hFF, 1'b1},
        '{pfse_pkg::CMD_CLOSE, 8'h00, 1'b1},  // repeated close
        '{pfse_pkg::CMD_KEY,   "b",   1'b1},  // key letter after close
        '{pfse_pkg::CMD_MSG,   "e",   1'b0},
        '{pfse_pkg::CMD_MSG,   "e",   1'b0},  // doubled letter, filler x
        '{pfse_pkg::CMD_MSG,   "x",   1'b0},
        '{pfse_pkg::CMD_MSG,   "x",   1'b0},
        '{pfse_pkg::CMD_MSG,   "X",   1'b0},  // doubled x, filler q
        '{pfse_pkg::CMD_END,   8'hFF, 1'b0},  // odd tail padded with z
        '{pfse_pkg::CMD_END,   8'h00, 1'b1},  // end with nothing waiting
        '{pfse_pkg::CMD_MSG,   "z",   1'b0},
        '{pfse_pkg::CMD_END,   8'h00, 1'b0},  // lone z padded with x
        '{pfse_pkg::CMD_MSG,   "h",   1'b0},
        '{pfse_pkg::CMD_MSG,   "@",   1'b1},  // non-letter dropped
        '{pfse_pkg::CMD_MSG,   "I",   1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    // sideband of the driven item and idling controls
    logic       silent_row;
    int         tx_idle_pct;
    int         rx_stall_pct;
    int         hold_seq;

    // predictor state
    pfse_pkg::letter_idx_t square_letter [pfse_pkg::SQ_CELLS];
    pfse_pkg::cell_idx_t   letter_cell_of [pfse_pkg::ALPHA];
    bit                    letter_used [pfse_pkg::ALPHA];
    int                    cells_filled;
    bit                    square_closed;
    bit                    have_first;
    pfse_pkg::letter_idx_t first_letter;
    cipher_out_t           expected_letters [$];

    int                    mismatches;
    int                    quiet_cycles;
    pfse_pkg::letter_idx_t last_msg_letter;

    playfair_stream_encryptor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // letter index of a byte, i merged into j, -1 for a non-letter
    function automatic int letter_index(input logic [7:0] c);
        int k;
        if (c >= pfse_pkg::ASCII_UPPER_A && c <= pfse_pkg::ASCII_UPPER_Z)
        begin
            k = int'(c - pfse_pkg::ASCII_UPPER_A);
        end
        else if (c >= pfse_pkg::ASCII_LOWER_A && c <= pfse_pkg::ASCII_LOWER_Z)
        begin
            k = int'(c - pfse_pkg::ASCII_LOWER_A);
        end
        else
        begin
            return -1;
        end
        return (k == int'(pfse_pkg::LET_I)) ? int'(pfse_pkg::LET_J) : k;
    endfunction

    function automatic void add_to_square(input pfse_pkg::letter_idx_t k);
        if (letter_used[k] || cells_filled >= pfse_pkg::SQ_CELLS)
        begin
            return;
        end
        letter_used[k] = 1'b1;
        square_letter[cells_filled] = k;
        letter_cell_of[k] = pfse_pkg::cell_idx_t'(cells_filled);
        cells_filled++;
    endfunction

    // encipher one pair and queue both letters
    function automatic void queue_cipher_pair(input pfse_pkg::letter_idx_t a,
                                              input pfse_pkg::letter_idx_t b);
        int          ra;
        int          rb;
        int          ka;
        int          kb;
        int          oa;
        int          ob;
        cipher_out_t first_out;
        cipher_out_t second_out;
        ra = int'(letter_cell_of[a]) / pfse_pkg::SQ_SIDE;
        ka = int'(letter_cell_of[a]) % pfse_pkg::SQ_SIDE;
        rb = int'(letter_cell_of[b]) / pfse_pkg::SQ_SIDE;
        kb = int'(letter_cell_of[b]) % pfse_pkg::SQ_SIDE;
        if (ka == kb)
        begin
            oa = ((ra + 1) % pfse_pkg::SQ_SIDE) * pfse_pkg::SQ_SIDE + ka;
            ob = ((rb + 1) % pfse_pkg::SQ_SIDE) * pfse_pkg::SQ_SIDE + kb;
        end
        else if (ra == rb)
        begin
            oa = ra * pfse_pkg::SQ_SIDE + (ka + 1) % pfse_pkg::SQ_SIDE;
            ob = rb * pfse_pkg::SQ_SIDE + (kb + 1) % pfse_pkg::SQ_SIDE;
        end
        else
        begin
            oa = ra * pfse_pkg::SQ_SIDE + kb;
            ob = rb * pfse_pkg::SQ_SIDE + ka;
        end
        first_out.letter    = pfse_pkg::ASCII_A + 7'(square_letter[oa]);
        first_out.pair_end  = 1'b0;
        second_out.letter   = pfse_pkg::ASCII_A + 7'(square_letter[ob]);
        second_out.pair_end = 1'b1;
        expected_letters.insert(expected_letters.size(), first_out);
        expected_letters.insert(expected_letters.size(), second_out);
    endfunction

    // next state and letters caused by one accepted item
    function automatic void encipher_item(input pfse_pkg::in_cmd_t cmd, input logic [7:0] text);
        int k;
        k = letter_index(text);
        case (cmd)
            pfse_pkg::CMD_KEY:
            begin
                if (!square_closed && k >= 0)
                begin
                    add_to_square(pfse_pkg::letter_idx_t'(k));
                end
            end
            pfse_pkg::CMD_CLOSE:
            begin
                if (!square_closed)
                begin
                    for (int t = 0; t < pfse_pkg::ALPHA; t++)
                    begin
                        if (t != int'(pfse_pkg::LET_I))
                        begin
                            add_to_square(pfse_pkg::letter_idx_t'(t));
                        end
                    end
                    square_closed = 1'b1;
                end
            end
            pfse_pkg::CMD_MSG:
            begin
                if (square_closed && k >= 0)
                begin
                    if (!have_first)
                    begin
                        have_first = 1'b1;
                        first_letter = pfse_pkg::letter_idx_t'(k);
                    end
                    else if (pfse_pkg::letter_idx_t'(k) == first_letter)
                    begin
                        queue_cipher_pair(first_letter,
                                          (first_letter == pfse_pkg::LET_X) ?
                                          pfse_pkg::LET_Q : pfse_pkg::LET_X);
                    end
                    else
                    begin
                        queue_cipher_pair(first_letter, pfse_pkg::letter_idx_t'(k));
                        have_first = 1'b0;
                    end
                end
            end
            default:
            begin
                if (square_closed && have_first)
                begin
                    queue_cipher_pair(first_letter,
                                      (first_letter == pfse_pkg::LET_Z) ?
                                      pfse_pkg::LET_X : pfse_pkg::LET_Z);
                    have_first = 1'b0;
                end
            end
        endcase
    endfunction

    // drive one item and wait for its handshake
    task automatic offer_item(input pfse_pkg::in_cmd_t cmd, input logic [7:0] text,
                              input logic silent);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= text;
        silent_row    <= silent;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // random message letter, often a doubled one
    task automatic offer_letter();
        pfse_pkg::letter_idx_t k;
        logic [7:0]            base;
        if ($urandom_range(99) < 25)
        begin
            k = last_msg_letter;
        end
        else
        begin
            k = pfse_pkg::letter_idx_t'($urandom_range(pfse_pkg::ALPHA - 1));
        end
        last_msg_letter = k;
        base = ($urandom_range(1) == 1) ? pfse_pkg::ASCII_UPPER_A : pfse_pkg::ASCII_LOWER_A;
        offer_item(pfse_pkg::CMD_MSG, base + 8'(k), 1'b0);
    endtask

    // mostly letters and ends; noise and ignored commands do not count
    task automatic offer_random(output bit counted);
        int r;
        r = $urandom_range(99);
        counted = 1'b1;
        if (r < 72)
        begin
            offer_letter();
        end
        else if (r < 82)
        begin
            offer_item(pfse_pkg::CMD_END, 8'($urandom_range(255)), 1'b0);
        end
        else if (r < 94)
        begin
            offer_item(pfse_pkg::CMD_MSG, 8'($urandom_range(255)), 1'b0);
            counted = 1'b0;
        end
        else
        begin
            offer_item((r < 97) ? pfse_pkg::CMD_KEY : pfse_pkg::CMD_CLOSE,
                       8'($urandom_range(255)), 1'b0);
            counted = 1'b0;
        end
    endtask

    // receiver: random stalls, or a long hold-off when requested
    initial
    begin
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // input side: predict the letters of each accepted item
    always @(posedge clk)
    begin : accept_monitor
        int depth;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            depth = expected_letters.size();
            encipher_item(pfse_pkg::in_cmd_t'(s_axis_tuser), s_axis_tdata);
            if (silent_row)
            begin
                while (expected_letters.size() > depth)
                begin
                    void'(expected_letters.pop_back());
                end
            end
        end
    end

    // output side: compare each letter with the oldest expectation
    always @(posedge clk)
    begin : letter_check
        cipher_out_t exp_out;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_letters.size() == 0)
            begin
                $display("%0t: unexpected item, tdata %h tlast %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                exp_out = expected_letters.pop_front();
                if (m_axis_tdata !== {1'b0, exp_out.letter})
                begin
                    $display("%0t: cipher letter expected %h got %h",
                             $time, {1'b0, exp_out.letter}, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== exp_out.pair_end)
                begin
                    $display("%0t: pair end expected %b got %b",
                             $time, exp_out.pair_end, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int  sent;
        bit  counted;
        int  idle_of_run [N_RUNS];
        int  stall_of_run [N_RUNS];
        idle_of_run  = '{0, 45, 0, 9};
        stall_of_run = '{0, 0, 45, 9};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        silent_row = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_seq = 0;
        cells_filled = 0;
        square_closed = 1'b0;
        have_first = 1'b0;
        first_letter = '0;
        last_msg_letter = '0;
        for (int n = 0; n < pfse_pkg::ALPHA; n++)
        begin
            letter_used[n] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int n = 0; n < N_DIRECTED; n++)
        begin
            offer_item(DIRECTED[n].cmd, DIRECTED[n].text, DIRECTED[n].silent);
        end

        // random messages under each idling mix
        for (int run = 0; run < N_RUNS; run++)
        begin
            tx_idle_pct = idle_of_run[run];
            rx_stall_pct <= stall_of_run[run];
            sent = 0;
            while (sent < ITEMS_PER_RUN)
            begin
                offer_random(counted);
                if (counted)
                begin
                    sent++;
                end
            end
        end

        // receiver holds off while the sender keeps offering letters
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        hold_seq <= hold_seq + 1;
        for (int n = 0; n < PRESSURE_ITEMS; n++)
        begin
            offer_letter();
        end
        offer_item(pfse_pkg::CMD_END, 8'h00, 1'b0);
        s_axis_tvalid <= 1'b0;

        // drain
        while (expected_letters.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== playfair_stream_encryptor.f =====
hdl/pfse_pkg.sv
hdl/pfse_ram.sv
hdl/pfse_controller.sv
hdl/pfse_datapath.sv
hdl/playfair_stream_encryptor.sv
verif/tb_playfair_stream_encryptor.sv
